// File: src/dqap_pkg.sv
package dqap_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] OCTET_FORBIDDEN = 8'd255;
  localparam logic [1:0] MAX_GROUP_DIGITS = 2'd3;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;
  localparam logic [2:0] DOT_SATURATE = 3'd4;
  localparam int unsigned NUM_OCTETS = 4;

  typedef struct packed {
    logic error_seen;
    logic [2:0] dot_count;
    logic [1:0] group_digit_count;
    logic [NUM_OCTETS-1:0][7:0] octet_store;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_CLEAR = '0;

endpackage

// File: src/dqap_char_step.sv
module dqap_char_step
  import dqap_pkg::*;
(
  input  parse_state_t cur,
  input  logic [7:0]   character,
  output parse_state_t nxt
);

  logic [1:0] idx;
  logic [7:0] digit;
  logic [7:0] old_octet;
  logic [7:0] new_octet;
  logic       is_digit;

  assign idx = cur.dot_count[1:0];
  assign digit = character - CH_ZERO;
  assign old_octet = cur.octet_store[idx];
  // value*10 + digit, kept to 8 bits as a byte store would
  assign new_octet = {old_octet[4:0], 3'b000} + {old_octet[6:0], 1'b0} + digit;
  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);

  always_comb begin
    nxt = cur;
    if (!cur.error_seen) begin
      if (character == CH_DOT) begin
        nxt.group_digit_count = '0;
        if (cur.dot_count < DOT_SATURATE) begin
          nxt.dot_count = cur.dot_count + 3'd1;
        end
      end else if (!is_digit) begin
        nxt.error_seen = 1'b1;
      end else if (cur.group_digit_count >= MAX_GROUP_DIGITS) begin
        nxt.error_seen = 1'b1;
      end else begin
        nxt.group_digit_count = cur.group_digit_count + 2'd1;
        if (!cur.dot_count[2]) begin
          nxt.octet_store[idx] = new_octet;
        end
      end
    end
  end

endmodule

// File: src/dotted_quad_address_parser.sv
// Dotted-decimal IPv4 address parser.
// Input channel (char_valid/char_ready): one byte of address text per beat,
// with last_character high on the final byte of each string.
// Output channel (result_valid/result_ready): one beat per string, carrying
// status (0 valid, 1 malformed or forbidden) and the four octets, which read
// as zero when status is 1.
// Throughput: one character per cycle while char_ready is high; each digit is
// folded into its octet by a single multiply-by-ten-and-add step.
// Latency: the result beat appears the cycle after the marked final character
// is accepted.
// The result sits in one output register. While it waits unaccepted,
// char_ready is low; when result_ready is high the register is drained and
// refilled in the same cycle, so strings can follow back to back.
// Reset clears the parse state and empties the output register.
module dotted_quad_address_parser
  import dqap_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] character,
  input  logic       last_character,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       status,
  output logic [7:0] octet_first,
  output logic [7:0] octet_second,
  output logic [7:0] octet_third,
  output logic [7:0] octet_fourth
);

  parse_state_t state;
  parse_state_t state_next;
  logic         accept;
  logic         bad;

  dqap_char_step u_step (
    .cur       (state),
    .character (character),
    .nxt       (state_next)
  );

  assign char_ready = !result_valid || result_ready;
  assign accept = char_valid && char_ready;

  always_comb begin
    bad = state_next.error_seen || (state_next.dot_count != DOTS_NEEDED);
    for (int k = 0; k < NUM_OCTETS; k++) begin
      if (state_next.octet_store[k] == OCTET_FORBIDDEN) begin
        bad = 1'b1;
      end
    end
    if (state_next.octet_store[0] == 8'd0 || state_next.octet_store[3] == 8'd0) begin
      bad = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_STATE_CLEAR;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        if (last_character) begin
          state <= PARSE_STATE_CLEAR;
          result_valid <= 1'b1;
        end else begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_character) begin
      status <= bad;
      octet_first <= bad ? 8'd0 : state_next.octet_store[0];
      octet_second <= bad ? 8'd0 : state_next.octet_store[1];
      octet_third <= bad ? 8'd0 : state_next.octet_store[2];
      octet_fourth <= bad ? 8'd0 : state_next.octet_store[3];
    end
  end

endmodule

// File: src/dqap_checker.sv
module dqap_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input logic       last_character,
  input logic       result_valid,
  input logic       result_ready,
  input logic       status,
  input logic [7:0] octet_first,
  input logic [7:0] octet_second,
  input logic [7:0] octet_third,
  input logic [7:0] octet_fourth
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat present just after reset");

  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_ready && last_character |=> result_valid)
    else $error("no result beat after final character");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> char_ready)
    else $error("input stalled with empty output register");

  a_error_octets_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |->
      octet_first == 8'd0 && octet_second == 8'd0 &&
      octet_third == 8'd0 && octet_fourth == 8'd0)
    else $error("error result carries non-zero octets");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status))
    else $error("stalled result beat dropped or changed");

endmodule

bind dotted_quad_address_parser dqap_checker u_dqap_checker (
  .clk            (clk),
  .rst            (rst),
  .char_valid     (char_valid),
  .char_ready     (char_ready),
  .last_character (last_character),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .status         (status),
  .octet_first    (octet_first),
  .octet_second   (octet_second),
  .octet_third    (octet_third),
  .octet_fourth   (octet_fourth)
);
